@@ rtl/core/cone_box_overlap_test_unit_macros.svh @@
// Assertion helpers for the cone/box overlap unit.
// Both sample on clk and are off while rst_n is low.
`ifndef CONE_BOX_OVERLAP_TEST_UNIT_MACROS_SVH
`define CONE_BOX_OVERLAP_TEST_UNIT_MACROS_SVH

// same-cycle implication
`define CBO_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CBO_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/cbo_pkg.sv @@
`default_nettype none

package cbo_pkg;

  localparam int CFG_DATA_W = 33;
  localparam int CFG_IDX_W  = 3;
  localparam int RANGE_W    = 33;

  // squared-distance path: offsets of 2^17 or more are out of range
  localparam int SQ_OP_W = 17;
  localparam int SQ_W    = 2 * SQ_OP_W;
  localparam int DIST_W  = SQ_W + 1;

  localparam int NUM_EDGES = 3;
  localparam int NUM_TERMS = 4;

  // box projection terms per edge axis
  localparam int BT_MIN_X = 0;
  localparam int BT_MAX_X = 1;
  localparam int BT_MIN_Y = 2;
  localparam int BT_MAX_Y = 3;

  // triangle projection terms per edge axis: edge start vertex i, opposite vertex k
  localparam int TP_I_X = 0;
  localparam int TP_I_Y = 1;
  localparam int TP_K_X = 2;
  localparam int TP_K_Y = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ORIGIN_X = 3'd0,
    REG_ORIGIN_Y = 3'd1,
    REG_RIGHT_X  = 3'd2,
    REG_RIGHT_Y  = 3'd3,
    REG_LEFT_X   = 3'd4,
    REG_LEFT_Y   = 3'd5,
    REG_RANGE_SQ = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic up_valid;  // upstream stage holds an item
    logic take;      // this stage may load
  } stage_ctl_t;

endpackage

`default_nettype wire

@@ rtl/core/cbo_cfg.sv @@
`default_nettype none

module cbo_cfg #(
  parameter int COORD_BITS = 16
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_we,
  input  wire logic [cbo_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [cbo_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  output logic signed [COORD_BITS-1:0]          tri_x [cbo_pkg::NUM_EDGES],
  output logic signed [COORD_BITS-1:0]          tri_y [cbo_pkg::NUM_EDGES],
  output logic [cbo_pkg::RANGE_W-1:0]           range_sq,
  output logic signed [COORD_BITS:0]            axis_x [cbo_pkg::NUM_EDGES],
  output logic signed [COORD_BITS:0]            axis_y [cbo_pkg::NUM_EDGES],
  output logic [cbo_pkg::NUM_EDGES-1:0]         axis_zero
);

  localparam int AW = COORD_BITS + 1;

  logic signed [COORD_BITS-1:0] tx_r [cbo_pkg::NUM_EDGES];
  logic signed [COORD_BITS-1:0] ty_r [cbo_pkg::NUM_EDGES];
  logic [cbo_pkg::RANGE_W-1:0]  range_r;
  logic signed [AW-1:0]         ax_r [cbo_pkg::NUM_EDGES];
  logic signed [AW-1:0]         ay_r [cbo_pkg::NUM_EDGES];
  logic signed [AW-1:0]         ax_nxt [cbo_pkg::NUM_EDGES];
  logic signed [AW-1:0]         ay_nxt [cbo_pkg::NUM_EDGES];
  logic [cbo_pkg::NUM_EDGES-1:0] zero_r;
  logic [cbo_pkg::NUM_EDGES-1:0] zero_nxt;
  logic signed [COORD_BITS-1:0] wcoord;

  assign wcoord = COORD_BITS'(cfg_wdata);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < cbo_pkg::NUM_EDGES; i++) begin
        tx_r[i] <= '0;
        ty_r[i] <= '0;
      end
      range_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        cbo_pkg::REG_ORIGIN_X: tx_r[0] <= wcoord;
        cbo_pkg::REG_ORIGIN_Y: ty_r[0] <= wcoord;
        cbo_pkg::REG_RIGHT_X:  tx_r[1] <= wcoord;
        cbo_pkg::REG_RIGHT_Y:  ty_r[1] <= wcoord;
        cbo_pkg::REG_LEFT_X:   tx_r[2] <= wcoord;
        cbo_pkg::REG_LEFT_Y:   ty_r[2] <= wcoord;
        cbo_pkg::REG_RANGE_SQ: range_r <= cbo_pkg::RANGE_W'(cfg_wdata);
        default: ;
      endcase
    end
  end

  // edge normal of edge i -> i+1 is (-ey, ex)
  always_comb begin
    int j;
    for (int i = 0; i < cbo_pkg::NUM_EDGES; i++) begin
      j = (i == cbo_pkg::NUM_EDGES - 1) ? 0 : i + 1;
      ax_nxt[i]   = AW'(ty_r[i]) - AW'(ty_r[j]);
      ay_nxt[i]   = AW'(tx_r[j]) - AW'(tx_r[i]);
      zero_nxt[i] = (ax_nxt[i] == '0) && (ay_nxt[i] == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < cbo_pkg::NUM_EDGES; i++) begin
        ax_r[i] <= '0;
        ay_r[i] <= '0;
      end
      zero_r <= '1;
    end else begin
      for (int i = 0; i < cbo_pkg::NUM_EDGES; i++) begin
        ax_r[i] <= ax_nxt[i];
        ay_r[i] <= ay_nxt[i];
      end
      zero_r <= zero_nxt;
    end
  end

  assign tri_x     = tx_r;
  assign tri_y     = ty_r;
  assign range_sq  = range_r;
  assign axis_x    = ax_r;
  assign axis_y    = ay_r;
  assign axis_zero = zero_r;

endmodule

`default_nettype wire

@@ rtl/core/cbo_front.sv @@
`default_nettype none

// Stage 1: clamp the apex into the box, keep offset magnitudes.
module cbo_front #(
  parameter int COORD_BITS = 16
) (
  input  wire logic                         clk,
  input  wire cbo_pkg::stage_ctl_t          ctl,
  input  wire logic signed [COORD_BITS-1:0] origin_x,
  input  wire logic signed [COORD_BITS-1:0] origin_y,
  input  wire logic signed [COORD_BITS-1:0] box_min_x,
  input  wire logic signed [COORD_BITS-1:0] box_min_y,
  input  wire logic signed [COORD_BITS-1:0] box_max_x,
  input  wire logic signed [COORD_BITS-1:0] box_max_y,
  output logic signed [COORD_BITS-1:0]      min_x_r,
  output logic signed [COORD_BITS-1:0]      min_y_r,
  output logic signed [COORD_BITS-1:0]      max_x_r,
  output logic signed [COORD_BITS-1:0]      max_y_r,
  output logic [COORD_BITS:0]               mag_x_r,
  output logic [COORD_BITS:0]               mag_y_r
);

  localparam int DW = COORD_BITS + 1;

  logic signed [COORD_BITS-1:0] clamp_x, clamp_y;
  logic signed [DW-1:0]         dx, dy;
  logic [DW-1:0]                mag_x_nxt, mag_y_nxt;

  // low bound tested first: inverted box gives min below min, else max
  always_comb begin
    if (origin_x < box_min_x)      clamp_x = box_min_x;
    else if (origin_x > box_max_x) clamp_x = box_max_x;
    else                           clamp_x = origin_x;
    if (origin_y < box_min_y)      clamp_y = box_min_y;
    else if (origin_y > box_max_y) clamp_y = box_max_y;
    else                           clamp_y = origin_y;
    dx = DW'(origin_x) - DW'(clamp_x);
    dy = DW'(origin_y) - DW'(clamp_y);
    mag_x_nxt = dx[DW-1] ? DW'(-dx) : DW'(dx);
    mag_y_nxt = dy[DW-1] ? DW'(-dy) : DW'(dy);
  end

  always_ff @(posedge clk) begin
    if (ctl.take && ctl.up_valid) begin
      min_x_r <= box_min_x;
      min_y_r <= box_min_y;
      max_x_r <= box_max_x;
      max_y_r <= box_max_y;
      mag_x_r <= mag_x_nxt;
      mag_y_r <= mag_y_nxt;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/cbo_mult.sv @@
`default_nettype none

// Stage 2: all projection products, distance squares, x/y axis tests.
module cbo_mult #(
  parameter int COORD_BITS = 16
) (
  input  wire logic                         clk,
  input  wire cbo_pkg::stage_ctl_t          ctl,
  input  wire logic signed [COORD_BITS-1:0] min_x,
  input  wire logic signed [COORD_BITS-1:0] min_y,
  input  wire logic signed [COORD_BITS-1:0] max_x,
  input  wire logic signed [COORD_BITS-1:0] max_y,
  input  wire logic [COORD_BITS:0]          mag_x,
  input  wire logic [COORD_BITS:0]          mag_y,
  input  wire logic signed [COORD_BITS-1:0] tri_x [cbo_pkg::NUM_EDGES],
  input  wire logic signed [COORD_BITS-1:0] tri_y [cbo_pkg::NUM_EDGES],
  input  wire logic signed [COORD_BITS:0]   axis_x [cbo_pkg::NUM_EDGES],
  input  wire logic signed [COORD_BITS:0]   axis_y [cbo_pkg::NUM_EDGES],
  output logic [cbo_pkg::SQ_W-1:0]          sq_x_r,
  output logic [cbo_pkg::SQ_W-1:0]          sq_y_r,
  output logic                              far_r,
  output logic                              xy_ok_r,
  output logic signed [2*COORD_BITS:0]      box_p_r [cbo_pkg::NUM_EDGES][cbo_pkg::NUM_TERMS],
  output logic signed [2*COORD_BITS:0]      tri_p_r [cbo_pkg::NUM_EDGES][cbo_pkg::NUM_TERMS]
);

  localparam int PW = 2 * COORD_BITS + 1;

  logic [cbo_pkg::SQ_OP_W-1:0]  op_x, op_y;
  logic [cbo_pkg::SQ_W-1:0]     sq_x_nxt, sq_y_nxt;
  logic                         far_nxt, xy_ok_nxt;
  logic signed [PW-1:0]         box_p_nxt [cbo_pkg::NUM_EDGES][cbo_pkg::NUM_TERMS];
  logic signed [PW-1:0]         tri_p_nxt [cbo_pkg::NUM_EDGES][cbo_pkg::NUM_TERMS];
  logic signed [COORD_BITS-1:0] t01_lo, t01_hi, tx_lo, tx_hi;
  logic signed [COORD_BITS-1:0] u01_lo, u01_hi, ty_lo, ty_hi;
  logic signed [COORD_BITS-1:0] bx_lo, bx_hi, by_lo, by_hi;

  always_comb begin
    op_x     = cbo_pkg::SQ_OP_W'(mag_x);
    op_y     = cbo_pkg::SQ_OP_W'(mag_y);
    far_nxt  = ((mag_x >> cbo_pkg::SQ_OP_W) != '0) || ((mag_y >> cbo_pkg::SQ_OP_W) != '0);
    sq_x_nxt = cbo_pkg::SQ_W'(op_x) * cbo_pkg::SQ_W'(op_x);
    sq_y_nxt = cbo_pkg::SQ_W'(op_y) * cbo_pkg::SQ_W'(op_y);
  end

  always_comb begin
    logic [1:0] k;
    for (int i = 0; i < cbo_pkg::NUM_EDGES; i++) begin
      k = (i == 0) ? 2'd2 : 2'(i - 1);
      box_p_nxt[i][cbo_pkg::BT_MIN_X] = PW'(min_x) * PW'(axis_x[i]);
      box_p_nxt[i][cbo_pkg::BT_MAX_X] = PW'(max_x) * PW'(axis_x[i]);
      box_p_nxt[i][cbo_pkg::BT_MIN_Y] = PW'(min_y) * PW'(axis_y[i]);
      box_p_nxt[i][cbo_pkg::BT_MAX_Y] = PW'(max_y) * PW'(axis_y[i]);
      tri_p_nxt[i][cbo_pkg::TP_I_X]   = PW'(tri_x[i]) * PW'(axis_x[i]);
      tri_p_nxt[i][cbo_pkg::TP_I_Y]   = PW'(tri_y[i]) * PW'(axis_y[i]);
      tri_p_nxt[i][cbo_pkg::TP_K_X]   = PW'(tri_x[k]) * PW'(axis_x[i]);
      tri_p_nxt[i][cbo_pkg::TP_K_Y]   = PW'(tri_y[k]) * PW'(axis_y[i]);
    end
  end

  // x and y axes: plain interval tests
  always_comb begin
    t01_lo = (tri_x[0] < tri_x[1]) ? tri_x[0] : tri_x[1];
    t01_hi = (tri_x[0] < tri_x[1]) ? tri_x[1] : tri_x[0];
    tx_lo  = (t01_lo < tri_x[2]) ? t01_lo : tri_x[2];
    tx_hi  = (t01_hi > tri_x[2]) ? t01_hi : tri_x[2];
    u01_lo = (tri_y[0] < tri_y[1]) ? tri_y[0] : tri_y[1];
    u01_hi = (tri_y[0] < tri_y[1]) ? tri_y[1] : tri_y[0];
    ty_lo  = (u01_lo < tri_y[2]) ? u01_lo : tri_y[2];
    ty_hi  = (u01_hi > tri_y[2]) ? u01_hi : tri_y[2];
    bx_lo  = (min_x < max_x) ? min_x : max_x;
    bx_hi  = (min_x < max_x) ? max_x : min_x;
    by_lo  = (min_y < max_y) ? min_y : max_y;
    by_hi  = (min_y < max_y) ? max_y : min_y;
    xy_ok_nxt = !(tx_hi < bx_lo || bx_hi < tx_lo) && !(ty_hi < by_lo || by_hi < ty_lo);
  end

  always_ff @(posedge clk) begin
    if (ctl.take && ctl.up_valid) begin
      sq_x_r  <= sq_x_nxt;
      sq_y_r  <= sq_y_nxt;
      far_r   <= far_nxt;
      xy_ok_r <= xy_ok_nxt;
      box_p_r <= box_p_nxt;
      tri_p_r <= tri_p_nxt;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/cbo_reduce.sv @@
`default_nettype none

// Stage 3: range compare and projection sums per edge axis.
module cbo_reduce #(
  parameter int COORD_BITS = 16
) (
  input  wire logic                         clk,
  input  wire cbo_pkg::stage_ctl_t          ctl,
  input  wire logic [cbo_pkg::SQ_W-1:0]     sq_x,
  input  wire logic [cbo_pkg::SQ_W-1:0]     sq_y,
  input  wire logic                         far,
  input  wire logic                         xy_ok,
  input  wire logic [cbo_pkg::RANGE_W-1:0]  range_sq,
  input  wire logic signed [2*COORD_BITS:0] box_p [cbo_pkg::NUM_EDGES][cbo_pkg::NUM_TERMS],
  input  wire logic signed [2*COORD_BITS:0] tri_p [cbo_pkg::NUM_EDGES][cbo_pkg::NUM_TERMS],
  output logic                              in_range_r,
  output logic                              xy_ok_r,
  output logic signed [2*COORD_BITS+1:0]    box_lo_r [cbo_pkg::NUM_EDGES],
  output logic signed [2*COORD_BITS+1:0]    box_hi_r [cbo_pkg::NUM_EDGES],
  output logic signed [2*COORD_BITS+1:0]    tri_i_r [cbo_pkg::NUM_EDGES],
  output logic signed [2*COORD_BITS+1:0]    tri_k_r [cbo_pkg::NUM_EDGES]
);

  localparam int PW = 2 * COORD_BITS + 1;
  localparam int SW = PW + 1;

  logic [cbo_pkg::DIST_W-1:0] dist_sum;
  logic                       in_range_nxt;
  logic signed [PW-1:0]       xl, xh, yl, yh;
  logic signed [SW-1:0]       box_lo_nxt [cbo_pkg::NUM_EDGES];
  logic signed [SW-1:0]       box_hi_nxt [cbo_pkg::NUM_EDGES];
  logic signed [SW-1:0]       tri_i_nxt [cbo_pkg::NUM_EDGES];
  logic signed [SW-1:0]       tri_k_nxt [cbo_pkg::NUM_EDGES];

  always_comb begin
    dist_sum     = cbo_pkg::DIST_W'(sq_x) + cbo_pkg::DIST_W'(sq_y);
    in_range_nxt = !far && (dist_sum <= cbo_pkg::DIST_W'(range_sq));
  end

  // box terms separate per axis, so the corner extremes are sums of term extremes
  always_comb begin
    xl = '0;
    xh = '0;
    yl = '0;
    yh = '0;
    for (int i = 0; i < cbo_pkg::NUM_EDGES; i++) begin
      xl = (box_p[i][cbo_pkg::BT_MIN_X] < box_p[i][cbo_pkg::BT_MAX_X]) ?
           box_p[i][cbo_pkg::BT_MIN_X] : box_p[i][cbo_pkg::BT_MAX_X];
      xh = (box_p[i][cbo_pkg::BT_MIN_X] < box_p[i][cbo_pkg::BT_MAX_X]) ?
           box_p[i][cbo_pkg::BT_MAX_X] : box_p[i][cbo_pkg::BT_MIN_X];
      yl = (box_p[i][cbo_pkg::BT_MIN_Y] < box_p[i][cbo_pkg::BT_MAX_Y]) ?
           box_p[i][cbo_pkg::BT_MIN_Y] : box_p[i][cbo_pkg::BT_MAX_Y];
      yh = (box_p[i][cbo_pkg::BT_MIN_Y] < box_p[i][cbo_pkg::BT_MAX_Y]) ?
           box_p[i][cbo_pkg::BT_MAX_Y] : box_p[i][cbo_pkg::BT_MIN_Y];
      box_lo_nxt[i] = SW'(xl) + SW'(yl);
      box_hi_nxt[i] = SW'(xh) + SW'(yh);
      tri_i_nxt[i]  = SW'(tri_p[i][cbo_pkg::TP_I_X]) + SW'(tri_p[i][cbo_pkg::TP_I_Y]);
      tri_k_nxt[i]  = SW'(tri_p[i][cbo_pkg::TP_K_X]) + SW'(tri_p[i][cbo_pkg::TP_K_Y]);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.take && ctl.up_valid) begin
      in_range_r <= in_range_nxt;
      xy_ok_r    <= xy_ok;
      box_lo_r   <= box_lo_nxt;
      box_hi_r   <= box_hi_nxt;
      tri_i_r    <= tri_i_nxt;
      tri_k_r    <= tri_k_nxt;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/cbo_judge.sv @@
`default_nettype none

// Stage 4: interval tests on the edge axes, result register.
module cbo_judge #(
  parameter int COORD_BITS = 16
) (
  input  wire logic                         clk,
  input  wire cbo_pkg::stage_ctl_t          ctl,
  input  wire logic                         in_range,
  input  wire logic                         xy_ok,
  input  wire logic [cbo_pkg::NUM_EDGES-1:0] axis_zero,
  input  wire logic signed [2*COORD_BITS+1:0] box_lo [cbo_pkg::NUM_EDGES],
  input  wire logic signed [2*COORD_BITS+1:0] box_hi [cbo_pkg::NUM_EDGES],
  input  wire logic signed [2*COORD_BITS+1:0] tri_i [cbo_pkg::NUM_EDGES],
  input  wire logic signed [2*COORD_BITS+1:0] tri_k [cbo_pkg::NUM_EDGES],
  output logic                              hit_r,
  output logic                              in_range_r
);

  logic [cbo_pkg::NUM_EDGES-1:0] axis_ok;
  logic                          hit_nxt;

  // triangle interval on edge i is spanned by vertex i and the opposite vertex
  always_comb begin
    for (int i = 0; i < cbo_pkg::NUM_EDGES; i++) begin
      axis_ok[i] = axis_zero[i] ||
                   !((tri_i[i] < box_lo[i] && tri_k[i] < box_lo[i]) ||
                     (box_hi[i] < tri_i[i] && box_hi[i] < tri_k[i]));
    end
    hit_nxt = in_range && xy_ok && (&axis_ok);
  end

  always_ff @(posedge clk) begin
    if (ctl.take && ctl.up_valid) begin
      hit_r      <= hit_nxt;
      in_range_r <= in_range;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/cone_box_overlap_test_unit.sv @@
// Channel | Direction | Ports                                            | Handshake
// cfg     | in        | cfg_we, cfg_index, cfg_wdata                     | write on cfg_we
// in      | in        | in_box_min_x, in_box_min_y, in_box_max_x/_y      | in_valid/in_ready
// out     | out       | out_hit, out_in_range                            | out_valid/out_ready
//
// One item per cycle sustained while out_ready stays high; an accepted item passes
// through four register stages: clamp, multipliers, sums, interval compares.
// rst_n (synchronous) clears valid bits and config registers to zero; axis_zero resets to ones.
// Each stage has its own valid bit and loads when it is empty or its successor moves,
// so an output stall fills bubbles first and then holds in_ready low.
`default_nettype none

`include "cone_box_overlap_test_unit_macros.svh"

module cone_box_overlap_test_unit #(
  parameter int COORD_BITS = 16
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [cbo_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [cbo_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic signed [COORD_BITS-1:0]   in_box_min_x,
  input  wire logic signed [COORD_BITS-1:0]   in_box_min_y,
  input  wire logic signed [COORD_BITS-1:0]   in_box_max_x,
  input  wire logic signed [COORD_BITS-1:0]   in_box_max_y,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic                                out_hit,
  output logic                                out_in_range
);

  localparam int PW = 2 * COORD_BITS + 1;
  localparam int SW = PW + 1;

  logic signed [COORD_BITS-1:0]  tri_x [cbo_pkg::NUM_EDGES];
  logic signed [COORD_BITS-1:0]  tri_y [cbo_pkg::NUM_EDGES];
  logic [cbo_pkg::RANGE_W-1:0]   range_sq;
  logic signed [COORD_BITS:0]    axis_x [cbo_pkg::NUM_EDGES];
  logic signed [COORD_BITS:0]    axis_y [cbo_pkg::NUM_EDGES];
  logic [cbo_pkg::NUM_EDGES-1:0] axis_zero;

  logic v1_r, v2_r, v3_r, v4_r;
  logic v1_nxt, v2_nxt, v3_nxt, v4_nxt;
  logic rdy1, rdy2, rdy3, rdy4;
  cbo_pkg::stage_ctl_t ctl1, ctl2, ctl3, ctl4;

  logic signed [COORD_BITS-1:0] s1_min_x, s1_min_y, s1_max_x, s1_max_y;
  logic [COORD_BITS:0]          s1_mag_x, s1_mag_y;

  logic [cbo_pkg::SQ_W-1:0] s2_sq_x, s2_sq_y;
  logic                     s2_far, s2_xy_ok;
  logic signed [PW-1:0]     s2_box_p [cbo_pkg::NUM_EDGES][cbo_pkg::NUM_TERMS];
  logic signed [PW-1:0]     s2_tri_p [cbo_pkg::NUM_EDGES][cbo_pkg::NUM_TERMS];

  logic                 s3_in_range, s3_xy_ok;
  logic signed [SW-1:0] s3_box_lo [cbo_pkg::NUM_EDGES];
  logic signed [SW-1:0] s3_box_hi [cbo_pkg::NUM_EDGES];
  logic signed [SW-1:0] s3_tri_i [cbo_pkg::NUM_EDGES];
  logic signed [SW-1:0] s3_tri_k [cbo_pkg::NUM_EDGES];

  // ready ripples back from the output
  always_comb begin
    rdy4 = !v4_r || out_ready;
    rdy3 = !v3_r || rdy4;
    rdy2 = !v2_r || rdy3;
    rdy1 = !v1_r || rdy2;
    v1_nxt = rdy1 ? in_valid : v1_r;
    v2_nxt = rdy2 ? v1_r : v2_r;
    v3_nxt = rdy3 ? v2_r : v3_r;
    v4_nxt = rdy4 ? v3_r : v4_r;
    ctl1 = '{up_valid: in_valid, take: rdy1};
    ctl2 = '{up_valid: v1_r, take: rdy2};
    ctl3 = '{up_valid: v2_r, take: rdy3};
    ctl4 = '{up_valid: v3_r, take: rdy4};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
      v3_r <= v3_nxt;
      v4_r <= v4_nxt;
    end
  end

  assign in_ready  = rdy1;
  assign out_valid = v4_r;

  cbo_cfg #(.COORD_BITS(COORD_BITS)) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .tri_x     (tri_x),
    .tri_y     (tri_y),
    .range_sq  (range_sq),
    .axis_x    (axis_x),
    .axis_y    (axis_y),
    .axis_zero (axis_zero)
  );

  cbo_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk       (clk),
    .ctl       (ctl1),
    .origin_x  (tri_x[0]),
    .origin_y  (tri_y[0]),
    .box_min_x (in_box_min_x),
    .box_min_y (in_box_min_y),
    .box_max_x (in_box_max_x),
    .box_max_y (in_box_max_y),
    .min_x_r   (s1_min_x),
    .min_y_r   (s1_min_y),
    .max_x_r   (s1_max_x),
    .max_y_r   (s1_max_y),
    .mag_x_r   (s1_mag_x),
    .mag_y_r   (s1_mag_y)
  );

  cbo_mult #(.COORD_BITS(COORD_BITS)) u_mult (
    .clk     (clk),
    .ctl     (ctl2),
    .min_x   (s1_min_x),
    .min_y   (s1_min_y),
    .max_x   (s1_max_x),
    .max_y   (s1_max_y),
    .mag_x   (s1_mag_x),
    .mag_y   (s1_mag_y),
    .tri_x   (tri_x),
    .tri_y   (tri_y),
    .axis_x  (axis_x),
    .axis_y  (axis_y),
    .sq_x_r  (s2_sq_x),
    .sq_y_r  (s2_sq_y),
    .far_r   (s2_far),
    .xy_ok_r (s2_xy_ok),
    .box_p_r (s2_box_p),
    .tri_p_r (s2_tri_p)
  );

  cbo_reduce #(.COORD_BITS(COORD_BITS)) u_reduce (
    .clk        (clk),
    .ctl        (ctl3),
    .sq_x       (s2_sq_x),
    .sq_y       (s2_sq_y),
    .far        (s2_far),
    .xy_ok      (s2_xy_ok),
    .range_sq   (range_sq),
    .box_p      (s2_box_p),
    .tri_p      (s2_tri_p),
    .in_range_r (s3_in_range),
    .xy_ok_r    (s3_xy_ok),
    .box_lo_r   (s3_box_lo),
    .box_hi_r   (s3_box_hi),
    .tri_i_r    (s3_tri_i),
    .tri_k_r    (s3_tri_k)
  );

  cbo_judge #(.COORD_BITS(COORD_BITS)) u_judge (
    .clk        (clk),
    .ctl        (ctl4),
    .in_range   (s3_in_range),
    .xy_ok      (s3_xy_ok),
    .axis_zero  (axis_zero),
    .box_lo     (s3_box_lo),
    .box_hi     (s3_box_hi),
    .tri_i      (s3_tri_i),
    .tri_k      (s3_tri_k),
    .hit_r      (out_hit),
    .in_range_r (out_in_range)
  );

  `CBO_ASSERT_NOW(a_hit_needs_range, out_valid, !out_hit || out_in_range, "hit without in_range")
  `CBO_ASSERT_NOW(a_stall_means_full, !in_ready, v1_r && v2_r && v3_r && v4_r, "input stalled with a bubble")
  `CBO_ASSERT_NEXT(a_accept_lands, in_valid && in_ready, v1_r, "accepted item missing from stage one")

endmodule

`default_nettype wire
